// ===== sv/dde_pkg.sv =====
// Package for the decimal digit emitter: width mode codes, digit counts,
// the link and emit structs shared by the cell chain and the top level.
// No dependencies.
package dde_pkg;

    localparam int unsigned NUM_CELLS = 10;
    localparam int unsigned CNT_W     = 4;

    // width mode codes
    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_HALF = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // digit counts per mode
    localparam logic [CNT_W-1:0] DIGITS_BYTE = 4'd3;
    localparam logic [CNT_W-1:0] DIGITS_HALF = 4'd5;
    localparam logic [CNT_W-1:0] DIGITS_WORD = 4'd10;

    localparam logic [7:0] BASE_RESET = 8'd16;

    // reciprocal of ten, scaled by 2^35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    // item state handed from one cell to the next
    typedef struct packed {
        logic             vld;
        logic [31:0]      value;
        logic             pad;
        logic [7:0]       start_col;
        logic [7:0]       row;
        logic [CNT_W-1:0] ndig;
    } dde_link_t;

    // one tile write offered by a cell
    typedef struct packed {
        logic       vld;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] tile;
        logic       last;
    } dde_emit_t;

endpackage

// ===== sv/dde_cell.sv =====
// One digit position of the emitter chain: holds the remaining value,
// peels off one decimal digit and hands the quotient to the next cell.
// Depends on dde_pkg.
module dde_cell
    import dde_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] base,
    input  dde_link_t  link_in,
    output dde_link_t  link_out,
    output dde_emit_t  emit
);

    localparam logic [CNT_W-1:0] LAST_NDIG = CNT_W'(CELL_IDX + 1);
    localparam logic [7:0]       COL_OFS   = 8'(CELL_IDX);
    localparam logic             FIRST     = (CELL_IDX == 0);

    logic        vld_reg;
    logic        vld_next;
    dde_link_t   cur_reg;

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] ten_quot;
    logic [31:0] rem;
    logic [3:0]  digit;
    logic        is_last;
    logic [7:0]  tile;

    // advance the valid flag along the chain
    assign vld_next = link_in.vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // hold the item payload
    always_ff @(posedge clk)
    begin
        cur_reg <= link_in;
    end

    // divide by ten through the reciprocal, recover the digit
    assign prod     = {32'd0, cur_reg.value} * {32'd0, RECIP_TEN};
    assign quot     = {3'd0, prod[63:RECIP_SHIFT]};
    assign ten_quot = {quot[28:0], 3'd0} + {quot[30:0], 1'd0};
    assign rem      = cur_reg.value - ten_quot;
    assign digit    = rem[3:0];

    assign is_last = (cur_reg.ndig == LAST_NDIG);

    // pick digit tile, zero tile or blank
    always_comb
    begin
        if ((cur_reg.value != 32'd0) || FIRST)
        begin
            tile = base + {4'd0, digit};
        end
        else if (cur_reg.pad)
        begin
            tile = base;
        end
        else
        begin
            tile = 8'd0;
        end
    end

    // offer this position, gated so the top level can OR the cells
    always_comb
    begin
        emit      = '0;
        emit.vld  = vld_reg;
        if (vld_reg)
        begin
            emit.col  = cur_reg.start_col - COL_OFS;
            emit.row  = cur_reg.row;
            emit.tile = tile;
            emit.last = is_last;
        end
    end

    // hand the quotient on while positions remain
    always_comb
    begin
        link_out       = cur_reg;
        link_out.vld   = vld_reg && !is_last;
        link_out.value = quot;
    end

endmodule

// ===== sv/decimal_digit_emitter.sv =====
// Decimal digit emitter: a start accepted into the first cell gives its first
// tile write on the ports through the output register, then one write per
// cycle, 3/5/10 writes for byte/16-bit/32-bit mode, none for the ignored mode.
// busy keeps a new item from overlapping the last one; the single result port
// sets that. The receiver cannot stall. Reset clears the chain, busy and the
// strobe and sets zero_tile_base to 16.
module decimal_digit_emitter
    import dde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        zero_tile_base_we,
    input  logic [7:0]  zero_tile_base_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] value,
    input  logic        zero_pad,
    input  logic [7:0]  start_col,
    input  logic [7:0]  row,
    output logic        strobe,
    output logic [7:0]  col,
    output logic [7:0]  out_row,
    output logic [7:0]  tile_code,
    output logic        last
);

    logic [7:0]       base_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic [CNT_W-1:0] ndig;
    logic [31:0]      masked;
    logic             pad_eff;
    dde_link_t        head;
    dde_link_t        links [NUM_CELLS+1];
    dde_emit_t        emits [NUM_CELLS];
    dde_emit_t        merged;

    logic             strobe_reg;
    logic [7:0]       col_reg;
    logic [7:0]       row_reg;
    logic [7:0]       tile_reg;
    logic             last_reg;

    // hold the zero tile register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (zero_tile_base_we)
        begin
            base_reg <= zero_tile_base_wdata;
        end
    end

    assign accept = start && !busy;
    assign busy   = (cnt_reg != '0);

    // decode the width mode
    always_comb
    begin
        unique case (req_type)
            MODE_BYTE:
            begin
                ndig    = DIGITS_BYTE;
                masked  = {24'd0, value[7:0]};
                pad_eff = zero_pad;
            end
            MODE_HALF:
            begin
                ndig    = DIGITS_HALF;
                masked  = {16'd0, value[15:0]};
                pad_eff = zero_pad;
            end
            MODE_WORD:
            begin
                ndig    = DIGITS_WORD;
                masked  = value;
                pad_eff = 1'b0;
            end
            MODE_NONE:
            begin
                ndig    = '0;
                masked  = value;
                pad_eff = 1'b0;
            end
        endcase
    end

    // count down the cycles until the next item may enter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = (ndig == '0) ? '0 : ndig - CNT_W'(1);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // build the item for the first cell
    always_comb
    begin
        head.vld       = accept && (ndig != '0);
        head.value     = masked;
        head.pad       = pad_eff;
        head.start_col = start_col;
        head.row       = row;
        head.ndig      = ndig;
    end

    assign links[0] = head;

    // chain of digit cells
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        dde_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .base     (base_reg),
            .link_in  (links[g]),
            .link_out (links[g+1]),
            .emit     (emits[g])
        );
    end

    // merge the cells; at most one offers a write per cycle
    always_comb
    begin
        merged = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            merged = merged | emits[i];
        end
    end

    // register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= merged.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= merged.col;
        row_reg  <= merged.row;
        tile_reg <= merged.tile;
        last_reg <= merged.last;
    end

    assign strobe    = strobe_reg;
    assign col       = col_reg;
    assign out_row   = row_reg;
    assign tile_code = tile_reg;
    assign last      = last_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for decimal_digit_emitter: drives digit print requests, predicts every tile write.
// Depends on dde_pkg (mode codes, digit counts) and the decimal_digit_emitter RTL.
module tb_top;
    import dde_pkg::*;

    localparam logic [31:0] RADIX      = 32'd10;
    localparam int          SETTLE_CYC = 14;
    localparam int          MAX_SHOWN  = 10;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] number;
        logic        pad;
        logic [7:0]  col0;
        logic [7:0]  row;
    } digit_req_t;

    typedef struct {
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] tile;
        logic       last;
    } tile_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        zero_tile_base_we = 1'b0;
    logic [7:0]  zero_tile_base_wdata = 8'd0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = MODE_BYTE;
    logic [31:0] value = 32'd0;
    logic        zero_pad = 1'b0;
    logic [7:0]  start_col = 8'd0;
    logic [7:0]  row = 8'd0;
    logic        strobe;
    logic [7:0]  col;
    logic [7:0]  out_row;
    logic [7:0]  tile_code;
    logic        last;

    digit_req_t  pending_reqs[$];
    tile_write_t tile_writes_due[$];
    digit_req_t  cur_req;
    logic [7:0]  zero_base = BASE_RESET;
    logic        took = 1'b0;
    logic        gaps_on = 1'b1;
    int          gap_left = 0;
    int          calm_left = 0;
    int          reqs_queued = 0;
    int          reqs_accepted = 0;
    int          err_count = 0;

    decimal_digit_emitter dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .zero_tile_base_we    (zero_tile_base_we),
        .zero_tile_base_wdata (zero_tile_base_wdata),
        .start                (start),
        .busy                 (busy),
        .req_type             (req_type),
        .value                (value),
        .zero_pad             (zero_pad),
        .start_col            (start_col),
        .row                  (row),
        .strobe               (strobe),
        .col                  (col),
        .out_row              (out_row),
        .tile_code            (tile_code),
        .last                 (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expand one request into the tile writes it must produce, LSD first
    function automatic void expand_digits(input digit_req_t r);
        logic [31:0] num;
        logic [31:0] digit;
        logic        padding;
        int          ndig;
        tile_write_t w;
        num     = r.number;
        padding = r.pad;
        case (r.mode)
            MODE_BYTE:
            begin
                ndig = int'(DIGITS_BYTE);
                num  = num & 32'h0000_00FF;
            end
            MODE_HALF:
            begin
                ndig = int'(DIGITS_HALF);
                num  = num & 32'h0000_FFFF;
            end
            MODE_WORD:
            begin
                ndig    = int'(DIGITS_WORD);
                padding = 1'b0;
            end
            default: ndig = 0;
        endcase
        w.col = r.col0;
        w.row = r.row;
        for (int i = 0; i < ndig; i++)
        begin
            digit = num % RADIX;
            if (num != 32'd0 || i == 0)
                w.tile = zero_base + digit[7:0];
            else if (padding)
                w.tile = zero_base;
            else
                w.tile = 8'd0;
            num    = num / RADIX;
            w.last = (i == ndig - 1);
            tile_writes_due.push_back(w);
            w.col = w.col - 8'd1;
        end
    endfunction

    // Driver: hold an item until taken, then insert a gap or present the next one
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !took))
        begin
            took = 1'b0;
            if (gap_left == 0 && gaps_on && calm_left == 0 && pending_reqs.size() > 0
                && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 5);
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                req_type  <= cur_req.mode;
                value     <= cur_req.number;
                zero_pad  <= cur_req.pad;
                start_col <= cur_req.col0;
                row       <= cur_req.row;
                start     <= 1'b1;
                if (calm_left > 0)
                    calm_left = calm_left - 1;
                else if ($urandom_range(0, 15) == 0)
                    calm_left = $urandom_range(8, 24);
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: track the base register, predict taken items, check tile writes
    always @(posedge clk)
    begin : monitor
        tile_write_t due;
        if (rst_n)
        begin
            if (zero_tile_base_we)
                zero_base = zero_tile_base_wdata;

            if (strobe)
            begin
                if (tile_writes_due.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("tb_top: unexpected tile write col=%0d row=%0d tile=%0d last=%0d",
                                 col, out_row, tile_code, last);
                end
                else
                begin
                    due = tile_writes_due.pop_front();
                    if (col !== due.col || out_row !== due.row || tile_code !== due.tile
                        || last !== due.last)
                    begin
                        err_count++;
                        if (err_count <= MAX_SHOWN)
                            $display({"tb_top: mismatch expected col=%0d row=%0d tile=%0d",
                                      " last=%0d, got col=%0d row=%0d tile=%0d last=%0d"},
                                     due.col, due.row, due.tile, due.last,
                                     col, out_row, tile_code, last);
                    end
                end
            end

            if (start && !busy)
            begin
                took = 1'b1;
                reqs_accepted++;
                expand_digits(cur_req);
            end
        end
    end

    task automatic queue_req(input logic [1:0] mode, input logic [31:0] number,
                             input logic pad, input logic [7:0] col0,
                             input logic [7:0] row_i);
        digit_req_t r;
        r.mode   = mode;
        r.number = number;
        r.pad    = pad;
        r.col0   = col0;
        r.row    = row_i;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // Queue n printing items with random content, plus ignored ones mixed in
    task automatic queue_random(input int n);
        int          made;
        logic [1:0]  mode;
        logic [31:0] num;
        int unsigned pow10[10];
        made = 0;
        pow10[0] = 1;
        for (int k = 1; k < 10; k++)
            pow10[k] = pow10[k-1] * 10;
        while (made < n)
        begin
            if ($urandom_range(0, 11) == 0)
                mode = MODE_NONE;
            else
                mode = 2'($urandom_range(0, 2));
            case ($urandom_range(0, 5))
                0: num = $urandom_range(0, 9);
                1: num = $urandom_range(0, 999);
                2: num = $urandom_range(0, 99999);
                3: num = pow10[$urandom_range(0, 9)] - $urandom_range(0, 1);
                default: num = $urandom;
            endcase
            queue_req(mode, num, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            if (mode != MODE_NONE)
                made++;
        end
    endtask

    // Wait until every item is taken and every tile write has come, then drain
    task automatic settle();
        while (reqs_accepted != reqs_queued || tile_writes_due.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_base(input logic [7:0] base);
        @(negedge clk);
        zero_tile_base_we    <= 1'b1;
        zero_tile_base_wdata <= base;
        @(negedge clk);
        zero_tile_base_we <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, value zero, masking, column wrap, ignored mode
        queue_req(MODE_BYTE, 32'd0,          1'b0, 8'd10,  8'd3);
        queue_req(MODE_BYTE, 32'd0,          1'b1, 8'd10,  8'd3);
        queue_req(MODE_BYTE, 32'd255,        1'b0, 8'd0,   8'd255);
        queue_req(MODE_BYTE, 32'hFFFF_FF07,  1'b1, 8'd1,   8'd0);
        queue_req(MODE_BYTE, 32'd100,        1'b0, 8'd128, 8'd64);
        queue_req(MODE_HALF, 32'd65535,      1'b0, 8'd255, 8'd128);
        queue_req(MODE_HALF, 32'h1234_0000,  1'b1, 8'd4,   8'd7);
        queue_req(MODE_HALF, 32'd10000,      1'b0, 8'd2,   8'd9);
        queue_req(MODE_HALF, 32'd42,         1'b1, 8'd100, 8'd1);
        queue_req(MODE_WORD, 32'd0,          1'b1, 8'd3,   8'd2);
        queue_req(MODE_WORD, 32'hFFFF_FFFF,  1'b0, 8'd9,   8'd254);
        queue_req(MODE_WORD, 32'd1000000000, 1'b1, 8'd200, 8'd5);
        queue_req(MODE_WORD, 32'd12345,      1'b1, 8'd20,  8'd6);
        queue_req(MODE_NONE, 32'hDEAD_BEEF,  1'b1, 8'd50,  8'd50);
        queue_req(MODE_NONE, 32'd0,          1'b0, 8'd0,   8'd0);
        settle();

        // top base: every nonzero digit wraps the tile code
        write_base(8'd255);
        queue_req(MODE_WORD, 32'd987654321, 1'b0, 8'd5, 8'd17);
        queue_req(MODE_BYTE, 32'd9,         1'b1, 8'd1, 8'd18);
        queue_random(60);
        settle();

        write_base(8'd0);
        queue_random(60);
        settle();

        write_base(8'($urandom_range(0, 255)));
        queue_random(60);
        settle();

        // last part at full rate, no gaps
        write_base(8'd250);
        gaps_on = 1'b0;
        queue_random(60);
        settle();

        while (tile_writes_due.size() > 0)
        begin
            void'(tile_writes_due.pop_front());
            err_count++;
        end
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dde_pkg.sv
sv/dde_cell.sv
sv/decimal_digit_emitter.sv
verif/tb_top.sv
